>>> sv/ibst_pkg.sv
// Shared constants, command and status codes and word types of the BST engine.
package ibst_pkg;

  localparam int NODES   = 31;
  localparam int IDX_W   = $clog2(NODES);
  localparam int WALK_W  = $clog2(2 * NODES + 1);
  localparam int VAL_W   = 32;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LEVEL  = 3'd1,
    CMD_IN     = 3'd2,
    CMD_PRE    = 3'd3,
    CMD_POST   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ELEMENT  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INS,
    BK_LEVEL,
    BK_DOWN,
    BK_UP,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    status_t                 status;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] key;
  } q_word_t;

  typedef struct packed {
    logic    valid;
    q_word_t word;
  } queue_if_t;

endpackage

>>> sv/ibst_front.sv
// Front end: takes command words, drops unknown codes, queues the rest.
module ibst_front
  import ibst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output queue_if_t q_o,
  input  logic      take_i
);

  q_word_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              cmd_ok, wr_en, pop;

  assign busy   = (cnt_r == QCNT_W'(QDEPTH));
  assign cmd_ok = (in_word.cmd <= CMD_CLEAR);
  assign wr_en  = start && !busy && cmd_ok;
  assign pop    = q_o.valid && take_i;

  assign q_o.valid = (cnt_r != '0);
  assign q_o.word  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({wr_en, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= '{cmd: cmd_t'(in_word.cmd), key: in_word.key_value};
    end
  end

endmodule

>>> sv/ibst_back.sv
// Back end: node store, insert walk, stackless traversals and result register.
module ibst_back
  import ibst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  queue_if_t q_i,
  output logic      take_o,
  output logic      out_valid,
  output out_word_t out_word
);

  back_state_t             state_r, state_nxt;
  logic [WALK_W-1:0]       k_r, k_nxt, parent, cur;
  cmd_t                    order_r, order_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;

  logic signed [VAL_W-1:0] node_value_r [NODES];
  logic [NODES-1:0]        node_used_r;

  logic                    pend_v_r, pend_v_nxt;
  logic signed [VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic                    cur_ok, cur_used, go_left;
  logic signed [VAL_W-1:0] cur_val;
  logic                    emit, fin, wr_en, clr_en;
  logic signed [VAL_W-1:0] emit_val;

  // in UP, k_r holds the child just left; the node worked on is its parent
  assign parent   = (k_r - WALK_W'(1)) >> 1;
  assign cur      = (state_r == BK_UP) ? parent : k_r;
  assign cur_ok   = (cur < WALK_W'(NODES));
  assign cur_used = cur_ok ? node_used_r[cur[IDX_W-1:0]] : 1'b0;
  assign cur_val  = cur_ok ? node_value_r[cur[IDX_W-1:0]] : '0;
  assign go_left  = (key_r < cur_val);
  assign take_o   = (state_r == BK_IDLE);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_i.valid) begin
          unique case (q_i.word.cmd) inside
            CMD_INSERT:                 state_nxt = BK_INS;
            CMD_LEVEL:                  state_nxt = BK_LEVEL;
            CMD_IN, CMD_PRE, CMD_POST:  state_nxt = BK_DOWN;
            default:                    state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_INS:   state_nxt = cur_used ? BK_INS : BK_IDLE;
      BK_LEVEL: state_nxt = (k_r == WALK_W'(NODES - 1)) ? BK_FIN : BK_LEVEL;
      BK_DOWN: begin
        if (cur_used)          state_nxt = BK_DOWN;
        else if (k_r == '0)    state_nxt = BK_FIN;
        else                   state_nxt = BK_UP;
      end
      BK_UP: begin
        if (k_r[0])            state_nxt = BK_DOWN;
        else if (parent == '0) state_nxt = BK_FIN;
        else                   state_nxt = BK_UP;
      end
      BK_FIN:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    k_nxt        = k_r;
    order_nxt    = order_r;
    key_nxt      = key_r;
    emit         = 1'b0;
    emit_val     = cur_val;
    fin          = 1'b0;
    wr_en        = 1'b0;
    clr_en       = 1'b0;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pend_v_nxt    = pend_v_r;
    pend_val_nxt  = pend_val_r;

    unique case (state_r)
      BK_IDLE: begin
        k_nxt = '0;
        if (q_i.valid) begin
          order_nxt = q_i.word.cmd;
          key_nxt   = q_i.word.key;
          clr_en    = (q_i.word.cmd == CMD_CLEAR);
        end
      end
      BK_INS: begin
        if (cur_used) begin
          k_nxt = go_left ? (k_r << 1) + WALK_W'(1) : (k_r << 1) + WALK_W'(2);
        end else begin
          wr_en         = cur_ok;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{out_value: key_r,
                            status: cur_ok ? ST_INSERTED : ST_OVERFLOW,
                            last: 1'b1};
        end
      end
      BK_LEVEL: begin
        emit  = cur_used;
        k_nxt = k_r + WALK_W'(1);
      end
      BK_DOWN: begin
        if (cur_used) begin
          emit  = (order_r == CMD_PRE);
          k_nxt = (k_r << 1) + WALK_W'(1);
        end
      end
      BK_UP: begin
        if (k_r[0]) begin
          emit  = (order_r == CMD_IN);
          k_nxt = k_r + WALK_W'(1);
        end else begin
          emit  = (order_r == CMD_POST);
          k_nxt = parent;
        end
      end
      BK_FIN: fin = 1'b1;
      default: ;
    endcase

    // one result held back so the final one can carry last
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = pend_v_r
                      ? out_word_t'{out_value: pend_val_r, status: ST_ELEMENT, last: 1'b1}
                      : out_word_t'{out_value: '0, status: ST_EMPTY, last: 1'b1};
      pend_v_nxt    = 1'b0;
    end else if (emit) begin
      out_valid_nxt = pend_v_r;
      out_word_nxt  = '{out_value: pend_val_r, status: ST_ELEMENT, last: 1'b0};
      pend_v_nxt    = 1'b1;
      pend_val_nxt  = emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      node_used_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_en) begin
        node_used_r <= '0;
      end else if (wr_en) begin
        node_used_r[cur[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    order_r    <= order_nxt;
    key_r      <= key_nxt;
    pend_val_r <= pend_val_nxt;
    out_word_r <= out_word_nxt;
    if (wr_en) begin
      node_value_r[cur[IDX_W-1:0]] <= key_r;
    end
  end

endmodule

>>> sv/implicit_array_bst_engine_top.sv
// Top level of the implicit-array binary search tree engine.
// Usage notes:
//  - Command channel: a word (cmd, key_value) is taken on a rising edge with start
//    high and busy low. A two-word queue sits in front of the engine, so a new
//    word is normally taken while the previous one is still being worked on;
//    busy rises only when that queue is full.
//  - Result channel: out_valid marks each result word for exactly one cycle;
//    the receiver cannot stall it, so every strobe must be taken.
//  - Insert: the back end pops the word, then walks one tree level per cycle from the
//    root, at most log2(NODES+1)+1 levels; its single word (inserted or overflow,
//    last set) is registered when the walk reaches a free slot or runs off the store.
//  - Traversals: the back end walks the tree without a stack, one step per
//    cycle: a descent into every stored node and empty child and a climb out of
//    every child; level order scans every slot in index order.
//    Each result is held until the next is found or the walk ends, as the last
//    flag is only known then; an empty tree gives one empty word.
//  - Clear: marks every slot unused, no result. Unknown command codes are dropped on entry.
//  - Reset (rst_n low, synchronous) empties the queue and marks every slot
//    unused; slot values are not cleared and are never read before written.
module implicit_array_bst_engine_top
  import ibst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  queue_if_t q;
  logic      take;

  // front end: accept, classify, queue
  ibst_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_word(in_word),
    .busy   (busy),
    .q_o    (q),
    .take_i (take)
  );

  // back end: node store and walks
  ibst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_i      (q),
    .take_o   (take),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

>>> sv/ibst_checker.sv
// Port-level checks of the BST engine, bound to the top level.
module ibst_checker
  import ibst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // insert results always close their command
  a_ins_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_INSERTED || out_word.status == ST_OVERFLOW)
    |-> out_word.last)
    else $error("insert result without last");

  // empty tree word is a lone zero word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_EMPTY) |-> out_word.last && (out_word.out_value == '0))
    else $error("bad empty-tree word");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // the queue only fills on an accepted word with a known command
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_word.cmd <= CMD_CLEAR)))
    else $error("busy rose without a word taken");

endmodule

bind implicit_array_bst_engine_top ibst_checker u_ibst_checker (.*);

>>> test/implicit_array_bst_engine_top_tb.sv
// Self-checking testbench for the implicit-array BST engine: directed table, then random words.
`timescale 1ns / 1ps

module implicit_array_bst_engine_top_tb
  import ibst_pkg::*;
();

  // spare command codes, dropped by the engine
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] KEY_ONES = -32'sd1;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 150;   // a full traversal walk plus margin
  localparam int RANDOM_WORDS = 105;

  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // shadow of the tree store
  logic signed [VAL_W-1:0] slot_val [NODES];
  bit                      slot_used[NODES];

  out_word_t awaited_words[$];   // results still owed by the engine, oldest first
  out_word_t step_words[$];      // results of the word just taken
  plan_row_t plan[$];
  int        mismatches = 0;
  int        cycles = 0;

  implicit_array_bst_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: every strobe must match the oldest owed word.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected result word: value %0d status %0d last %0d",
               out_word.out_value, out_word.status, out_word.last);
        mismatches++;
      end else begin
        exp_w = awaited_words.pop_front();
        if (out_word.out_value !== exp_w.out_value) begin
          $error("out_value: expected %0d, got %0d", exp_w.out_value, out_word.out_value);
          mismatches++;
        end
        if (out_word.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_word.status);
          mismatches++;
        end
        if (out_word.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_word.last);
          mismatches++;
        end
      end
    end
  end

  // Works out what one command word does to the shadow tree and which
  // result words it owes; leaves them in step_words.
  function automatic void tree_apply(input in_word_t w);
    int        k;
    bit        walk_cmd;
    int        order[$];
    int        stack[$];
    int        rev[$];
    out_word_t r;
    step_words.delete();
    walk_cmd = 1'b0;
    case (w.cmd)
      CMD_INSERT: begin
        k = 0;
        // equal keys go right
        while (k < NODES && slot_used[k])
          k = (w.key_value < slot_val[k]) ? 2 * k + 1 : 2 * k + 2;
        r.out_value = w.key_value;
        r.last      = 1'b1;
        if (k < NODES) begin
          slot_val[k]  = w.key_value;
          slot_used[k] = 1'b1;
          r.status     = ST_INSERTED;
        end else begin
          r.status = ST_OVERFLOW;
        end
        step_words.push_back(r);
      end
      CMD_LEVEL: begin
        walk_cmd = 1'b1;
        for (k = 0; k < NODES; k++)
          if (slot_used[k]) order.push_back(k);
      end
      CMD_IN: begin
        walk_cmd = 1'b1;
        k = 0;
        forever begin
          while (k < NODES && slot_used[k]) begin
            stack.push_back(k);
            k = 2 * k + 1;
          end
          if (stack.size() == 0) break;
          k = stack.pop_back();
          order.push_back(k);
          k = 2 * k + 2;
        end
      end
      CMD_PRE: begin
        walk_cmd = 1'b1;
        stack.push_back(0);
        while (stack.size() != 0) begin
          k = stack.pop_back();
          if (k < NODES && slot_used[k]) begin
            order.push_back(k);
            stack.push_back(2 * k + 2);
            stack.push_back(2 * k + 1);
          end
        end
      end
      CMD_POST: begin
        // root-right-left pre order, reversed
        walk_cmd = 1'b1;
        stack.push_back(0);
        while (stack.size() != 0) begin
          k = stack.pop_back();
          if (k < NODES && slot_used[k]) begin
            rev.push_back(k);
            stack.push_back(2 * k + 1);
            stack.push_back(2 * k + 2);
          end
        end
        for (k = rev.size() - 1; k >= 0; k--) order.push_back(rev[k]);
      end
      CMD_CLEAR: begin
        for (k = 0; k < NODES; k++) slot_used[k] = 1'b0;
      end
      default: ;
    endcase
    if (walk_cmd) begin
      if (order.size() == 0) begin
        r.out_value = '0;
        r.status    = ST_EMPTY;
        r.last      = 1'b1;
        step_words.push_back(r);
      end else begin
        for (k = 0; k < order.size(); k++) begin
          r.out_value = slot_val[order[k]];
          r.status    = ST_ELEMENT;
          r.last      = (k == order.size() - 1);
          step_words.push_back(r);
        end
      end
    end
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] cmd,
                                         input logic signed [VAL_W-1:0] key,
                                         input bit fixed, input status_t st);
    plan_row_t p;
    p.word.cmd       = cmd;
    p.word.key_value = key;
    p.fixed          = fixed;
    p.want.out_value = (st == ST_EMPTY) ? '0 : key;
    p.want.status    = st;
    p.want.last      = 1'b1;
    return p;
  endfunction

  // Presents a word from the next falling edge and holds it until taken.
  // Owed words are queued at the taking edge.
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t want);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    tree_apply(w);
    if (fixed) awaited_words.push_back(want);
    else foreach (step_words[i]) awaited_words.push_back(step_words[i]);
  endtask

  // Random sender gap; each idle cycle is its own falling edge.
  task automatic sender_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold off until the engine owes nothing.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_word_t  w;
    out_word_t no_want;
    int        idle_pct[3];
    int        taken;
    int        pick;
    int        ph;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    no_want    = '0;
    for (int i = 0; i < NODES; i++) begin
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
    end
    idle_pct = '{33, 80, 0};

    // Directed table. Fixed rows carry a single obvious result word.
    // Empty tree straight out of reset, every traversal
    plan.push_back(plan_row(CMD_LEVEL, '0, 1'b1, ST_EMPTY));
    plan.push_back(plan_row(CMD_IN,    '0, 1'b1, ST_EMPTY));
    plan.push_back(plan_row(CMD_PRE,   '0, 1'b1, ST_EMPTY));
    plan.push_back(plan_row(CMD_POST,  '0, 1'b1, ST_EMPTY));
    // extremes; a second zero checks that equal keys go right
    plan.push_back(plan_row(CMD_INSERT, '0,       1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_MAX,  1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_MIN,  1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, '0,       1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_ONES, 1'b1, ST_INSERTED));
    // spare codes: no result at all; then every traversal of the tree so far
    plan.push_back(plan_row(CMD_SPARE_A, '0,       1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_SPARE_B, KEY_ONES, 1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_LEVEL, '0, 1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_IN,    '0, 1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_PRE,   '0, 1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_POST,  '0, 1'b0, ST_EMPTY));
    // right spine fills down to the bottom slot, then the walk runs off the store
    plan.push_back(plan_row(CMD_INSERT, KEY_MAX, 1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_MAX, 1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_MAX, 1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_INSERT, KEY_MAX, 1'b1, ST_OVERFLOW));
    plan.push_back(plan_row(CMD_IN,     '0,      1'b0, ST_EMPTY));
    // clear, then the tree is empty again
    plan.push_back(plan_row(CMD_CLEAR,  '0,      1'b0, ST_EMPTY));
    plan.push_back(plan_row(CMD_LEVEL,  '0,      1'b1, ST_EMPTY));
    plan.push_back(plan_row(CMD_INSERT, KEY_MIN, 1'b1, ST_INSERTED));
    plan.push_back(plan_row(CMD_POST,   '0,      1'b0, ST_EMPTY));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      send_word(plan[i].word, plan[i].fixed, plan[i].want);
      sender_gap(25);
    end
    drain_results();

    // Random words: mostly inserts so the trees grow deep enough to overflow,
    // traversals of every order, the odd clear and a few spare codes.
    for (ph = 0; ph < 3; ph++) begin
      taken = 0;
      while (taken < RANDOM_WORDS / 3 + 1) begin
        sender_gap(idle_pct[ph]);
        pick        = $urandom_range(0, 99);
        w.key_value = $urandom;
        if (pick < 60 || pick >= 96) begin
          w.cmd = CMD_INSERT;
          case ($urandom_range(0, 9)) inside
            0: w.key_value = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            1, 2: w.key_value = $signed($urandom_range(0, 15)) - 8;  // repeats likely
            default: ;
          endcase
        end
        else if (pick < 67) w.cmd = CMD_LEVEL;
        else if (pick < 74) w.cmd = CMD_IN;
        else if (pick < 81) w.cmd = CMD_PRE;
        else if (pick < 88) w.cmd = CMD_POST;
        else if (pick < 93) w.cmd = CMD_CLEAR;
        else w.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        send_word(w, 1'b0, no_want);
        if (w.cmd != CMD_SPARE_A && w.cmd != CMD_SPARE_B) taken++;
      end
      drain_results();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ibst_pkg.sv
sv/ibst_front.sv
sv/ibst_back.sv
sv/implicit_array_bst_engine_top.sv
sv/ibst_checker.sv
test/implicit_array_bst_engine_top_tb.sv
